[rtl/core/pdt_pkg.sv]
// Shared types, constants and helper functions for the three-way pixel diff tally.
package pdt_pkg;

    localparam int RECT_SIDE_MAX = 2048;
    localparam int COL_W   = (RECT_SIDE_MAX > 2) ? $clog2(RECT_SIDE_MAX) : 1;
    localparam int SIDE_W  = COL_W + 1;
    localparam int RW_W    = 12;
    localparam int ORG_W   = 11;
    localparam int POS_W   = 12;
    localparam int CMP_W   = (SIDE_W > RW_W) ? SIDE_W : RW_W;
    localparam int SUM_W   = ((COL_W > ORG_W) ? COL_W : ORG_W) + 1;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 23;
    localparam int NUM_BUCKETS = 5;
    localparam int BKT_W   = 3;
    localparam int LANES   = 4;
    localparam int CFG_W   = 12;

    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(RECT_SIDE_MAX);

    localparam logic [1:0] METRIC_RAW   = 2'd0;
    localparam logic [1:0] METRIC_LANE8 = 2'd1;
    localparam logic [1:0] METRIC_5551  = 2'd2;

    localparam logic [BKT_W-1:0] BKT_ONE   = 3'd0;
    localparam logic [BKT_W-1:0] BKT_TWO   = 3'd1;
    localparam logic [BKT_W-1:0] BKT_LT16  = 3'd2;
    localparam logic [BKT_W-1:0] BKT_LT128 = 3'd3;
    localparam logic [BKT_W-1:0] BKT_HIGH  = 3'd4;

    localparam logic [4:0] LANE5551_SHIFT [LANES] = '{5'd0, 5'd5, 5'd10, 5'd15};
    localparam logic [4:0] LANE5551_MASK  [LANES] = '{5'd31, 5'd31, 5'd31, 5'd1};
    localparam logic [7:0] LANE5551_SCALE [LANES] = '{8'd8, 8'd8, 8'd8, 8'd255};

    typedef enum logic [1:0] {
        CFG_METRIC     = 2'd0,
        CFG_RECT_WIDTH = 2'd1,
        CFG_ORIGIN_X   = 2'd2,
        CFG_ORIGIN_Y   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REC_MOVERS = 2'd0,
        REC_HIST   = 2'd1,
        REC_FIRST  = 2'd2
    } rec_kind_t;

    typedef enum logic [1:0] {
        MOVER_FIRST  = 2'd0,
        MOVER_SECOND = 2'd1,
        MOVER_BOTH   = 2'd2
    } mover_t;

    typedef struct packed {
        logic [VAL_W-1:0] pre_value;
        logic [VAL_W-1:0] sw_value;
        logic [VAL_W-1:0] gpu_value;
        logic             last_pixel;
    } pix_t;

    typedef struct packed {
        logic [1:0]       record;
        logic             run_end;
        logic [VAL_W-1:0] payload_a;
        logic [VAL_W-1:0] payload_b;
        logic [VAL_W-1:0] payload_c;
        logic [VAL_W-1:0] payload_d;
        logic [VAL_W-1:0] payload_e;
        logic [VAL_W-1:0] payload_f;
    } rec_t;

    typedef struct packed {
        logic [RW_W-1:0]  rect_width;
        logic [ORG_W-1:0] origin_x;
        logic [ORG_W-1:0] origin_y;
    } geom_t;

    typedef struct packed {
        logic             last;
        logic             diff;
        mover_t           mover;
        logic [VAL_W-1:0] delta;
        logic [VAL_W-1:0] pre_value;
        logic [VAL_W-1:0] sw_value;
        logic [VAL_W-1:0] gpu_value;
    } stage_t;

    typedef struct packed {
        logic [CNT_W-1:0]                  pixels_seen;
        logic [CNT_W-1:0]                  first_only;
        logic [CNT_W-1:0]                  second_only;
        logic [CNT_W-1:0]                  both_moved;
        logic [VAL_W-1:0]                  peak;
        logic [NUM_BUCKETS-1:0][CNT_W-1:0] buckets;
        logic                              first_found;
        logic [POS_W-1:0]                  first_col;
        logic [POS_W-1:0]                  first_row;
        logic [VAL_W-1:0]                  diff_pre;
        logic [VAL_W-1:0]                  diff_sw;
        logic [VAL_W-1:0]                  diff_gpu;
    } tally_t;

    function automatic logic [VAL_W-1:0] abs_diff32(input logic [VAL_W-1:0] a,
                                                    input logic [VAL_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [7:0] worst_lane8(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
        logic [7:0] worst;
        logic [7:0] la;
        logic [7:0] lb;
        logic [7:0] d;
        worst = '0;
        for (int i = 0; i < LANES; i++)
        begin
            la = a[i*8 +: 8];
            lb = b[i*8 +: 8];
            d  = (la > lb) ? (la - lb) : (lb - la);
            if (d > worst)
            begin
                worst = d;
            end
        end
        return worst;
    endfunction

    function automatic logic [7:0] worst_lane5551(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        logic [7:0]  worst;
        logic [4:0]  la;
        logic [4:0]  lb;
        logic [4:0]  d;
        logic [12:0] scaled;
        worst = '0;
        for (int i = 0; i < LANES; i++)
        begin
            la     = 5'(a >> LANE5551_SHIFT[i]) & LANE5551_MASK[i];
            lb     = 5'(b >> LANE5551_SHIFT[i]) & LANE5551_MASK[i];
            d      = (la > lb) ? (la - lb) : (lb - la);
            scaled = 13'(d) * 13'(LANE5551_SCALE[i]);
            if (scaled[7:0] > worst)
            begin
                worst = scaled[7:0];
            end
        end
        return worst;
    endfunction

endpackage

[rtl/core/pdt_delta.sv]
// Input register and delta/mover classification stage.
module pdt_delta (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           pix_valid,
    input  pdt_pkg::pix_t  pix,
    input  logic [1:0]     metric,
    output logic           stg_valid,
    output pdt_pkg::stage_t stg
);
    import pdt_pkg::*;

    logic   in_valid_reg;
    pix_t   in_reg;
    logic   stg_valid_reg;
    stage_t stg_reg;
    stage_t stg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            stg_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg  <= pix_valid;
            stg_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg  <= pix;
            stg_reg <= stg_next;
        end
    end

    always_comb
    begin
        stg_next.last      = in_reg.last_pixel;
        stg_next.diff      = (in_reg.sw_value != in_reg.gpu_value);
        stg_next.pre_value = in_reg.pre_value;
        stg_next.sw_value  = in_reg.sw_value;
        stg_next.gpu_value = in_reg.gpu_value;
        if (in_reg.sw_value == in_reg.pre_value)
        begin
            stg_next.mover = MOVER_SECOND;
        end
        else if (in_reg.gpu_value == in_reg.pre_value)
        begin
            stg_next.mover = MOVER_FIRST;
        end
        else
        begin
            stg_next.mover = MOVER_BOTH;
        end
        case (metric)
            METRIC_LANE8: stg_next.delta = VAL_W'(worst_lane8(in_reg.sw_value,
                                                              in_reg.gpu_value));
            METRIC_5551:  stg_next.delta = VAL_W'(worst_lane5551(in_reg.sw_value,
                                                                 in_reg.gpu_value));
            default:      stg_next.delta = abs_diff32(in_reg.sw_value, in_reg.gpu_value);
        endcase
    end

    assign stg_valid = stg_valid_reg;
    assign stg       = stg_reg;

endmodule

[rtl/core/pdt_accum.sv]
// Tally accumulators, pixel position tracking and end-of-run snapshot.
module pdt_accum (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            stg_valid,
    input  pdt_pkg::stage_t stg,
    input  pdt_pkg::geom_t  geom,
    output logic            snap_load,
    output pdt_pkg::tally_t snap
);
    import pdt_pkg::*;

    tally_t            tally_reg;
    tally_t            tally_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [COL_W-1:0]  row_reg;
    logic [COL_W-1:0]  row_next;
    logic [SIDE_W-1:0] col_inc;
    logic [SIDE_W-1:0] row_inc;
    logic              col_wrap;
    logic [BKT_W-1:0]  bucket;
    logic [SUM_W-1:0]  pos_x;
    logic [SUM_W-1:0]  pos_y;
    logic              step;

    assign step      = adv && stg_valid;
    assign snap_load = step && stg.last;

    always_comb
    begin
        if (stg.delta == VAL_W'(1))
        begin
            bucket = BKT_ONE;
        end
        else if (stg.delta == VAL_W'(2))
        begin
            bucket = BKT_TWO;
        end
        else if (stg.delta < VAL_W'(16))
        begin
            bucket = BKT_LT16;
        end
        else if (stg.delta < VAL_W'(128))
        begin
            bucket = BKT_LT128;
        end
        else
        begin
            bucket = BKT_HIGH;
        end
    end

    assign pos_x = SUM_W'(geom.origin_x) + SUM_W'(col_reg);
    assign pos_y = SUM_W'(geom.origin_y) + SUM_W'(row_reg);

    always_comb
    begin
        tally_next             = tally_reg;
        tally_next.pixels_seen = tally_reg.pixels_seen + CNT_W'(1);
        if (stg.diff)
        begin
            case (stg.mover)
                MOVER_SECOND: tally_next.second_only = tally_reg.second_only + CNT_W'(1);
                MOVER_FIRST:  tally_next.first_only  = tally_reg.first_only + CNT_W'(1);
                default:      tally_next.both_moved  = tally_reg.both_moved + CNT_W'(1);
            endcase
            if (stg.delta > tally_reg.peak)
            begin
                tally_next.peak = stg.delta;
            end
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                if (bucket == BKT_W'(i))
                begin
                    tally_next.buckets[i] = tally_reg.buckets[i] + CNT_W'(1);
                end
            end
            if (!tally_reg.first_found)
            begin
                tally_next.first_found = 1'b1;
                tally_next.first_col   = pos_x[POS_W-1:0];
                tally_next.first_row   = pos_y[POS_W-1:0];
                tally_next.diff_pre    = stg.pre_value;
                tally_next.diff_sw     = stg.sw_value;
                tally_next.diff_gpu    = stg.gpu_value;
            end
        end
    end

    // column wraps at rect_width or the side limit; zero width acts as one
    always_comb
    begin
        col_inc  = SIDE_W'(col_reg) + SIDE_W'(1);
        row_inc  = SIDE_W'(row_reg) + SIDE_W'(1);
        col_wrap = (CMP_W'(col_inc) >= CMP_W'(geom.rect_width)) || (col_inc >= SIDE_MAX);
        if (col_wrap)
        begin
            col_next = '0;
            row_next = (row_inc >= SIDE_MAX) ? '0 : row_inc[COL_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else if (step)
        begin
            if (stg.last)
            begin
                tally_reg <= '0;
                col_reg   <= '0;
                row_reg   <= '0;
            end
            else
            begin
                tally_reg <= tally_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
            end
        end
    end

    assign snap = tally_next;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |=> (tally_reg.pixels_seen == '0) && !tally_reg.first_found
                      && (col_reg == '0) && (row_reg == '0))
        else $error("tally not cleared after last pixel");

    a_first_zero_until_found: assert property (@(posedge clk) disable iff (!rst_n)
        !tally_reg.first_found |-> (tally_reg.diff_pre == '0) && (tally_reg.diff_sw == '0)
                                   && (tally_reg.diff_gpu == '0)
                                   && (tally_reg.first_col == '0))
        else $error("first-difference capture set without a found flag");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !stg.last) |=> tally_reg.peak >= $past(tally_reg.peak))
        else $error("peak delta decreased within a run");
`endif

endmodule

[rtl/core/pdt_report.sv]
// Report buffer that holds one run's snapshot and sends its three records.
module pdt_report (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            snap_load,
    input  pdt_pkg::tally_t snap,
    output logic            rpt_free,
    output logic            rec_valid,
    input  logic            rec_ready,
    output pdt_pkg::rec_t   rec
);
    import pdt_pkg::*;

    tally_t    rpt_reg;
    logic      busy_reg;
    rec_kind_t idx_reg;
    logic      last_rec;

    assign last_rec = (idx_reg == REC_FIRST);
    assign rpt_free = !busy_reg || (rec_ready && last_rec);
    assign rec_valid = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= REC_MOVERS;
        end
        else if (snap_load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= REC_MOVERS;
        end
        else if (busy_reg && rec_ready)
        begin
            unique case (idx_reg)
                REC_MOVERS: idx_reg <= REC_HIST;
                REC_HIST:   idx_reg <= REC_FIRST;
                default:
                begin
                    idx_reg  <= REC_MOVERS;
                    busy_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            rpt_reg <= snap;
        end
    end

    always_comb
    begin
        rec.record  = idx_reg;
        rec.run_end = last_rec;
        unique case (idx_reg)
            REC_MOVERS:
            begin
                rec.payload_a = VAL_W'(rpt_reg.pixels_seen);
                rec.payload_b = VAL_W'(rpt_reg.first_only);
                rec.payload_c = VAL_W'(rpt_reg.second_only);
                rec.payload_d = VAL_W'(rpt_reg.both_moved);
                rec.payload_e = rpt_reg.peak;
                rec.payload_f = '0;
            end
            REC_HIST:
            begin
                rec.payload_a = VAL_W'(rpt_reg.buckets[0]);
                rec.payload_b = VAL_W'(rpt_reg.buckets[1]);
                rec.payload_c = VAL_W'(rpt_reg.buckets[2]);
                rec.payload_d = VAL_W'(rpt_reg.buckets[3]);
                rec.payload_e = VAL_W'(rpt_reg.buckets[4]);
                rec.payload_f = '0;
            end
            default:
            begin
                rec.payload_a = VAL_W'(rpt_reg.first_found);
                rec.payload_b = VAL_W'(rpt_reg.first_col);
                rec.payload_c = VAL_W'(rpt_reg.first_row);
                rec.payload_d = rpt_reg.diff_pre;
                rec.payload_e = rpt_reg.diff_sw;
                rec.payload_f = rpt_reg.diff_gpu;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |-> !busy_reg || (rec_ready && last_rec))
        else $error("snapshot loaded over an undelivered report");

    a_load_starts_report: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |=> busy_reg && (idx_reg == REC_MOVERS))
        else $error("report did not start with the mover record");

    a_done_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && rec_ready && last_rec && !snap_load) |=> !busy_reg)
        else $error("report still busy after its final record");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && rec_ready && !last_rec && !snap_load
            |=> (idx_reg == REC_HIST) || (idx_reg == REC_FIRST))
        else $error("record sequence skipped or repeated");
`endif

endmodule

[rtl/core/three_way_pixel_diff_tally.sv]
// Top level of the three-way pixel diff tally: config registers and pipeline flow control.
//
//  channel | signals                              | direction | transaction
//  --------+--------------------------------------+-----------+------------------------------
//  pix     | pix_valid, pix_ready, pix            | in        | one pixel (pre, sw, gpu, last)
//  rec     | rec_valid, rec_ready, rec            | out       | one record, three per run
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | in        | one register write
//
//  One pixel per clock unless stalled: input register, delta stage, accumulator
//  update. A run's last pixel is tallied once it leaves the delta stage; its
//  three records follow one per cycle from the report buffer while rec_ready is
//  high and new pixels keep flowing. The pipeline stalls only when a last pixel
//  reaches the accumulator while the previous run's records are still undelivered.
//  Reset clears all tallies and sets metric 1, width 1, origin 0,0.
module three_way_pixel_diff_tally (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  pdt_pkg::pix_t                       pix,
    output logic                                rec_valid,
    input  logic                                rec_ready,
    output pdt_pkg::rec_t                       rec,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  pdt_pkg::cfg_idx_t                   cfg_index,
    input  logic [pdt_pkg::CFG_W-1:0]           cfg_data
);
    import pdt_pkg::*;

    logic [1:0] metric_sel_reg;
    geom_t      geom_reg;
    logic       adv;
    logic       stall;
    logic       stg_valid;
    stage_t     stg;
    logic       snap_load;
    tally_t     snap;
    logic       rpt_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_sel_reg      <= METRIC_LANE8;
            geom_reg.rect_width <= RW_W'(1);
            geom_reg.origin_x   <= '0;
            geom_reg.origin_y   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_METRIC:     metric_sel_reg      <= cfg_data[1:0];
                CFG_RECT_WIDTH: geom_reg.rect_width <= cfg_data[RW_W-1:0];
                CFG_ORIGIN_X:   geom_reg.origin_x   <= cfg_data[ORG_W-1:0];
                CFG_ORIGIN_Y:   geom_reg.origin_y   <= cfg_data[ORG_W-1:0];
                default:        metric_sel_reg      <= metric_sel_reg;
            endcase
        end
    end

    assign stall     = stg_valid && stg.last && !rpt_free;
    assign adv       = !stall;
    assign pix_ready = adv;

    pdt_delta u_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .pix_valid (pix_valid),
        .pix       (pix),
        .metric    (metric_sel_reg),
        .stg_valid (stg_valid),
        .stg       (stg)
    );

    pdt_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .stg_valid (stg_valid),
        .stg       (stg),
        .geom      (geom_reg),
        .snap_load (snap_load),
        .snap      (snap)
    );

    pdt_report u_report (
        .clk       (clk),
        .rst_n     (rst_n),
        .snap_load (snap_load),
        .snap      (snap),
        .rpt_free  (rpt_free),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

`ifndef SYNTHESIS
    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> stg_valid && stg.last && rec_valid)
        else $error("input stalled without a pending report");

    a_metric_written: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && (cfg_index == CFG_METRIC))
            |=> (metric_sel_reg == $past(cfg_data[1:0])))
        else $error("metric write not taken");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> stg_valid && stg.last)
        else $error("stalled last pixel lost from the accumulator stage");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for three_way_pixel_diff_tally: directed and random pixel runs.
module tb;
    import pdt_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 8;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             pix_valid = 1'b0;
    logic             pix_ready;
    pix_t             pix       = '0;
    logic             rec_valid;
    logic             rec_ready = 1'b0;
    rec_t             rec;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    cfg_idx_t         cfg_index = CFG_METRIC;
    logic [CFG_W-1:0] cfg_data  = '0;

    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int hold_off_left    = 0;
    int cycle_count      = 0;
    int fail_count       = 0;
    int pixels_accepted  = 0;
    int records_checked  = 0;

    // tally model: configuration
    logic [1:0]       cur_metric = METRIC_LANE8;
    logic [RW_W-1:0]  cur_width  = 12'd1;
    logic [ORG_W-1:0] cur_ox     = '0;
    logic [ORG_W-1:0] cur_oy     = '0;

    // tally model: running state
    logic [COL_W-1:0] at_col   = '0;
    logic [COL_W-1:0] at_row   = '0;
    logic [CNT_W-1:0] n_pix    = '0;
    logic [CNT_W-1:0] n_first  = '0;
    logic [CNT_W-1:0] n_second = '0;
    logic [CNT_W-1:0] n_both   = '0;
    logic [VAL_W-1:0] top_delta = '0;
    logic [CNT_W-1:0] hist [NUM_BUCKETS];
    logic             found    = 1'b0;
    logic [POS_W-1:0] f_col    = '0;
    logic [POS_W-1:0] f_row    = '0;
    logic [VAL_W-1:0] f_pre    = '0;
    logic [VAL_W-1:0] f_sw     = '0;
    logic [VAL_W-1:0] f_gpu    = '0;

    rec_t expected_records [$];

    three_way_pixel_diff_tally dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [VAL_W-1:0] pixel_delta(input logic [1:0] m,
                                                     input logic [VAL_W-1:0] a,
                                                     input logic [VAL_W-1:0] b);
        int worst;
        int la;
        int lb;
        int d;
        worst = 0;
        case (m)
            METRIC_LANE8:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    la = a[8*i +: 8];
                    lb = b[8*i +: 8];
                    d  = (la > lb) ? la - lb : lb - la;
                    if (d > worst)
                    begin
                        worst = d;
                    end
                end
                return VAL_W'(worst);
            end
            METRIC_5551:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    la = a[5*i +: 5];
                    lb = b[5*i +: 5];
                    d  = 8 * ((la > lb) ? la - lb : lb - la);
                    if (d > worst)
                    begin
                        worst = d;
                    end
                end
                if (a[15] != b[15])
                begin
                    worst = 255;
                end
                return VAL_W'(worst);
            end
            default:
            begin
                return (a > b) ? a - b : b - a;
            end
        endcase
    endfunction

    task automatic clear_tally();
        at_col    = '0;
        at_row    = '0;
        n_pix     = '0;
        n_first   = '0;
        n_second  = '0;
        n_both    = '0;
        top_delta = '0;
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            hist[i] = '0;
        end
        found = 1'b0;
        f_col = '0;
        f_row = '0;
        f_pre = '0;
        f_sw  = '0;
        f_gpu = '0;
    endtask

    initial
    begin
        clear_tally();
    end

    task automatic tally_pixel(input pix_t px);
        logic [VAL_W-1:0] delta;
        int               bkt;
        int               nxt;
        rec_t             r;
        n_pix = n_pix + CNT_W'(1);
        if (px.sw_value != px.gpu_value)
        begin
            if (px.sw_value == px.pre_value)
            begin
                n_second = n_second + CNT_W'(1);
            end
            else if (px.gpu_value == px.pre_value)
            begin
                n_first = n_first + CNT_W'(1);
            end
            else
            begin
                n_both = n_both + CNT_W'(1);
            end
            delta = pixel_delta(cur_metric, px.sw_value, px.gpu_value);
            if (delta > top_delta)
            begin
                top_delta = delta;
            end
            if (delta == 1)
                bkt = BKT_ONE;
            else if (delta == 2)
                bkt = BKT_TWO;
            else if (delta < 16)
                bkt = BKT_LT16;
            else if (delta < 128)
                bkt = BKT_LT128;
            else
                bkt = BKT_HIGH;
            hist[bkt] = hist[bkt] + CNT_W'(1);
            if (!found)
            begin
                found = 1'b1;
                f_col = POS_W'(cur_ox) + POS_W'(at_col);
                f_row = POS_W'(cur_oy) + POS_W'(at_row);
                f_pre = px.pre_value;
                f_sw  = px.sw_value;
                f_gpu = px.gpu_value;
            end
        end
        nxt = int'(at_col) + 1;
        if (nxt >= int'(cur_width) || nxt >= RECT_SIDE_MAX)
        begin
            at_col = '0;
            at_row = at_row + COL_W'(1);
        end
        else
        begin
            at_col = COL_W'(nxt);
        end
        if (px.last_pixel)
        begin
            r = '0;
            r.record    = REC_MOVERS;
            r.payload_a = VAL_W'(n_pix);
            r.payload_b = VAL_W'(n_first);
            r.payload_c = VAL_W'(n_second);
            r.payload_d = VAL_W'(n_both);
            r.payload_e = top_delta;
            expected_records = {expected_records, r};
            r = '0;
            r.record    = REC_HIST;
            r.payload_a = VAL_W'(hist[BKT_ONE]);
            r.payload_b = VAL_W'(hist[BKT_TWO]);
            r.payload_c = VAL_W'(hist[BKT_LT16]);
            r.payload_d = VAL_W'(hist[BKT_LT128]);
            r.payload_e = VAL_W'(hist[BKT_HIGH]);
            expected_records = {expected_records, r};
            r = '0;
            r.record    = REC_FIRST;
            r.run_end   = 1'b1;
            r.payload_a = VAL_W'(found);
            r.payload_b = VAL_W'(f_col);
            r.payload_c = VAL_W'(f_row);
            r.payload_d = f_pre;
            r.payload_e = f_sw;
            r.payload_f = f_gpu;
            expected_records = {expected_records, r};
            clear_tally();
        end
    endtask

    // input-side monitor: pixel and register transactions
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && pix_ready)
        begin
            tally_pixel(pix);
            pixels_accepted++;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_METRIC:     cur_metric = cfg_data[1:0];
                CFG_RECT_WIDTH: cur_width  = cfg_data[RW_W-1:0];
                CFG_ORIGIN_X:   cur_ox     = cfg_data[ORG_W-1:0];
                CFG_ORIGIN_Y:   cur_oy     = cfg_data[ORG_W-1:0];
                default: ;
            endcase
        end
    end

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : rec_check
        rec_t want;
        if (rst_n && rec_valid && rec_ready)
        begin
            if (expected_records.size() == 0)
            begin
                $error("record transaction %0d with none expected", rec.record);
                fail_count++;
            end
            else
            begin
                want = expected_records.pop_front();
                check_field("record", VAL_W'(want.record), VAL_W'(rec.record));
                check_field("run_end", VAL_W'(want.run_end), VAL_W'(rec.run_end));
                check_field("payload_a", want.payload_a, rec.payload_a);
                check_field("payload_b", want.payload_b, rec.payload_b);
                check_field("payload_c", want.payload_c, rec.payload_c);
                check_field("payload_d", want.payload_d, rec.payload_d);
                check_field("payload_e", want.payload_e, rec.payload_e);
                check_field("payload_f", want.payload_f, rec.payload_f);
                records_checked++;
            end
        end
    end

    // record sink: random stalls plus an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            hold_off_left = hold_off_left - 1;
            rec_ready <= 1'b0;
        end
        else
        begin
            rec_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_pixel(input logic [VAL_W-1:0] p, input logic [VAL_W-1:0] s,
                              input logic [VAL_W-1:0] g, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= {p, s, g, last};
        @(posedge clk);
        while (!pix_ready)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [VAL_W-1:0] nudge(input logic [VAL_W-1:0] v);
        case ($urandom_range(3))
            0:       return v ^ (32'h1 << $urandom_range(31));
            1:       return v + $urandom_range(1, 200);
            2:       return v - $urandom_range(1, 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_pixel(input logic last);
        logic [VAL_W-1:0] p;
        logic [VAL_W-1:0] s;
        logic [VAL_W-1:0] g;
        p = $urandom;
        case ($urandom_range(9))
            0, 1:
            begin
                s = ($urandom_range(1)) ? p : nudge(p);
                g = s;
            end
            2, 3:
            begin
                s = p;
                g = nudge(p);
            end
            4, 5:
            begin
                s = nudge(p);
                g = p;
            end
            6, 7, 8:
            begin
                s = nudge(p);
                g = nudge(p);
            end
            default:
            begin
                s = $urandom;
                g = $urandom;
            end
        endcase
        send_pixel(p, s, g, last);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle_all();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (expected_records.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_pixel(32'h0, 32'h0, 32'h0, 1'b0);
        send_pixel(32'h5, 32'h5, 32'h6, 1'b0);
        send_pixel(32'h7, 32'h9, 32'h7, 1'b0);
        send_pixel(32'h0, 32'h10, 32'h20, 1'b0);
        send_pixel(32'h1, 32'hFF00_0000, 32'h0, 1'b0);
        send_pixel(32'h0A, 32'h0A, 32'h0, 1'b1);
        // run with nothing differing
        send_pixel(32'hFFFF_FFFF, 32'h1234_5678, 32'h1234_5678, 1'b1);
        settle_all();
    endtask

    task automatic test_metric_cases();
        for (int m = 0; m < 4; m++)
        begin
            write_reg(CFG_METRIC, CFG_W'(m));
            send_pixel(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
            send_pixel(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0);
            send_pixel(32'hFFFF_FFFF, 32'h0000_8000, 32'h0, 1'b0);
            send_pixel(32'h21, 32'h21, 32'h20, 1'b0);
            send_pixel(32'h0, 32'h2, 32'h0, 1'b1);
            settle_all();
        end
    endtask

    task automatic test_geometry();
        write_reg(CFG_METRIC, CFG_W'(METRIC_LANE8));
        write_reg(CFG_RECT_WIDTH, 12'd0);
        write_reg(CFG_ORIGIN_X, 12'd2047);
        write_reg(CFG_ORIGIN_Y, 12'd2047);
        repeat (3) send_pixel(32'h0, 32'h0, 32'h0, 1'b0);
        send_pixel(32'h1, 32'h3, 32'h1, 1'b1);
        settle_all();
        write_reg(CFG_RECT_WIDTH, 12'd3);
        write_reg(CFG_ORIGIN_X, 12'd5);
        write_reg(CFG_ORIGIN_Y, 12'd9);
        repeat (7) send_pixel(32'h8, 32'h8, 32'h8, 1'b0);
        send_pixel(32'h8, 32'h9, 32'h8, 1'b1);
        settle_all();
        // a width above the side limit keeps the column stepping
        write_reg(CFG_RECT_WIDTH, 12'd4095);
        write_reg(CFG_ORIGIN_X, 12'd2000);
        write_reg(CFG_ORIGIN_Y, 12'd0);
        repeat (4) send_pixel(32'h5, 32'h5, 32'h5, 1'b0);
        send_pixel(32'h0, 32'hC0, 32'h0, 1'b1);
        settle_all();
        write_reg(CFG_RECT_WIDTH, 12'd2048);
        repeat (4) send_random_pixel(1'b0);
        send_random_pixel(1'b1);
        settle_all();
    endtask

    task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
        int sent;
        int run_len;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        settle_all();
        write_reg(CFG_METRIC, CFG_W'($urandom_range(3)));
        write_reg(CFG_RECT_WIDTH, ($urandom_range(9) == 0) ? CFG_W'($urandom_range(4095))
                                                           : CFG_W'($urandom_range(1, 6)));
        write_reg(CFG_ORIGIN_X, CFG_W'($urandom_range(2047)));
        write_reg(CFG_ORIGIN_Y, CFG_W'($urandom_range(2047)));
        sent = 0;
        while (sent < n_items)
        begin
            run_len = $urandom_range(1, 12);
            for (int i = 1; i <= run_len; i++)
            begin
                send_random_pixel(i == run_len);
            end
            sent += run_len;
        end
        settle_all();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle_all();
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (16) send_random_pixel(1'b1);
        settle_all();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 7;
        recv_idle_pct = 63;
        test_reset_values();
        test_metric_cases();
        test_geometry();
        test_random_traffic(30, 7, 63);
        test_random_traffic(30, 63, 7);
        test_random_traffic(30, 0, 0);
        test_output_stall();
        settle_all();
        $display("Run covered %0d pixels and %0d records: all metrics, width and origin",
                 pixels_accepted, records_checked);
        $display("extremes, position wrap, random runs under stalls and a long output hold-off");
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
